### hdl/julia_escape_time_pixel_assert.svh
// Assertion macros shared by the pixel engine RTL.
// No dependencies; include with the bare file name after the module header.
`ifndef JULIA_ESCAPE_TIME_PIXEL_ASSERT_SVH
`define JULIA_ESCAPE_TIME_PIXEL_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define JETS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("julia_escape_time_pixel: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define JETS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("julia_escape_time_pixel: next-cycle check failed");

`else

`define JETS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define JETS_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

### hdl/jets_pkg.sv
// Shared constants for the Julia escape-time pixel engine.
// No dependencies; used by jets_mul and julia_escape_time_pixel.
`default_nettype none

package jets_pkg;

  // Fixed field widths
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned ITER_W    = 8;
  localparam int unsigned CHUNK_W   = 8;
  localparam int unsigned CFG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CONST_REAL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONST_IMAG  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_REAL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_IMAG   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_REAL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_IMAG = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_ID    = 3'd7;

  localparam logic [ITER_W-1:0] MAX_ITER_RESET = 8'd60;

  // Multiplier sequencing: four half-by-half partial products
  localparam int unsigned MUL_CNT_W = 3;
  localparam logic [MUL_CNT_W-1:0] MUL_LAST_STEP = 3'd4;

endpackage

`default_nettype wire

### hdl/jets_mul.sv
// Shared signed multiplier: four half-width partial products over several cycles.
// Depends on jets_pkg and julia_escape_time_pixel_assert.svh.
`default_nettype none

module jets_mul #(
  parameter int unsigned CW = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   go,
  input  wire logic signed [CW-1:0]   a,
  input  wire logic signed [CW-1:0]   b,
  output logic                        done,
  output logic signed [2*CW-1:0]      p
);

  `include "julia_escape_time_pixel_assert.svh"

  localparam int unsigned PW = 2 * CW;
  localparam int unsigned H  = (CW + 1) / 2;
  localparam int unsigned AW = 2 * H;

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_SIGN} mstate_t;

  mstate_t                          state_r;
  logic [jets_pkg::MUL_CNT_W-1:0]   cnt_r;
  logic [AW-1:0]                    a_mag_r, b_mag_r;
  logic                             neg_r;
  logic [AW-1:0]                    pp_r;
  logic [1:0]                       pstep_r;
  logic [PW-1:0]                    acc_r;
  logic signed [PW-1:0]             p_r;
  logic                             done_r;

  logic [CW-1:0] a_u, b_u, a_mag, b_mag;
  logic [H-1:0]  a_half, b_half;
  logic [PW-1:0] pp_ext, pp_shift;

  always_comb begin
    a_u    = a;
    b_u    = b;
    a_mag  = a_u[CW-1] ? (~a_u + 1'b1) : a_u;
    b_mag  = b_u[CW-1] ? (~b_u + 1'b1) : b_u;
    a_half = cnt_r[1] ? a_mag_r[AW-1:H] : a_mag_r[H-1:0];
    b_half = cnt_r[0] ? b_mag_r[AW-1:H] : b_mag_r[H-1:0];
    pp_ext = PW'(pp_r);
    case (pstep_r)
      2'd0:    pp_shift = pp_ext;
      2'd3:    pp_shift = pp_ext << (2 * H);
      default: pp_shift = pp_ext << H;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        M_IDLE: begin
          if (go) begin
            a_mag_r <= AW'(a_mag);
            b_mag_r <= AW'(b_mag);
            neg_r   <= a[CW-1] ^ b[CW-1];
            acc_r   <= '0;
            cnt_r   <= '0;
            state_r <= M_RUN;
          end
        end
        M_RUN: begin
          if (cnt_r != jets_pkg::MUL_LAST_STEP) begin
            pp_r    <= a_half * b_half;
            pstep_r <= cnt_r[1:0];
          end
          if (cnt_r != '0) begin
            acc_r <= acc_r + pp_shift;
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == jets_pkg::MUL_LAST_STEP) begin
            state_r <= M_SIGN;
          end
        end
        M_SIGN: begin
          p_r     <= neg_r ? signed'(~acc_r + 1'b1) : signed'(acc_r);
          done_r  <= 1'b1;
          state_r <= M_IDLE;
        end
        default: state_r <= M_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign p    = p_r;

  `JETS_ASSERT_NXT(a_mul_done_pulse, clk, rst_n, done_r, !done_r)
  `JETS_ASSERT_IMP(a_mul_go_idle, clk, rst_n, go, state_r == M_IDLE)
  `JETS_ASSERT_IMP(a_mul_sign, clk, rst_n, done_r && (p_r != '0), p_r[PW-1] == neg_r)

endmodule

`default_nettype wire

### hdl/julia_escape_time_pixel.sv
// Top level of the Julia escape-time pixel engine: config registers and sequencer.
// Depends on jets_pkg, jets_mul and julia_escape_time_pixel_assert.svh.
`default_nettype none

// One pixel word is taken when start is high and busy is low; busy stays high
// until the result word appears. The start point is formed with two passes of
// the shared multiplier (origin + index * step, saturated), then z = z^2 + c
// runs with three multiplies per iteration (re*re, im*im, re*im), all on one
// four-pass multiplier. The result word is shown on out_result_chunk /
// out_iterations for exactly one cycle with out_valid high; there is no
// back-pressure, so the receiver must capture it in that cycle. Configuration
// words go in through cfg_we / cfg_index / cfg_data and should be written only
// while busy is low.
module julia_escape_time_pixel #(
  parameter int unsigned FRAC_BITS   = 27,
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Pixel input
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [jets_pkg::PIX_W-1:0]          in_pixel_x,
  input  wire logic [jets_pkg::PIX_W-1:0]          in_pixel_y,
  // Result output
  output logic                                     out_valid,
  output logic [jets_pkg::CHUNK_W-1:0]             out_result_chunk,
  output logic [jets_pkg::ITER_W-1:0]              out_iterations,
  // Configuration write port
  input  wire logic                                cfg_we,
  input  wire logic [jets_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [COORD_WIDTH-1:0]              cfg_data
);

  `include "julia_escape_time_pixel_assert.svh"

  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned F    = FRAC_BITS;
  localparam int unsigned PW   = 2 * CW;          // full product
  localparam int unsigned DW   = PW + 1;          // difference / doubled product
  localparam int unsigned SUMW = PW + 2;          // before saturation
  // Magnitude sum must hold both squares and the limit 4.0 at 2*F fraction bits
  localparam int unsigned SW   = (PW + 2 > 2 * F + 4) ? PW + 2 : 2 * F + 4;
  localparam logic signed [SW-1:0] MAG_LIMIT =
    {{(SW - 2 * F - 3){1'b0}}, 1'b1, {(2 * F + 2){1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE, S_X, S_Y, S_TEST, S_RR, S_II, S_CHK, S_RI
  } state_t;

  // Clamp a wide signed sum into the coordinate range
  function automatic logic signed [CW-1:0] sat_coord(input logic signed [SUMW-1:0] x);
    logic [SUMW-CW:0] hi;
    hi = x[SUMW-1:CW-1];
    if ((hi == '0) || (hi == '1)) begin
      return x[CW-1:0];
    end else if (x[SUMW-1]) begin
      return {1'b1, {(CW-1){1'b0}}};
    end else begin
      return {1'b0, {(CW-1){1'b1}}};
    end
  endfunction

  // Configuration registers
  logic signed [CW-1:0]              const_real_r, const_imag_r;
  logic signed [CW-1:0]              step_real_r, step_imag_r;
  logic signed [CW-1:0]              origin_real_r, origin_imag_r;
  logic [jets_pkg::ITER_W-1:0]       max_iter_r;
  logic [jets_pkg::CHUNK_W-1:0]      chunk_id_r;

  // Sequencer and datapath registers
  state_t                            state_r;
  logic [jets_pkg::PIX_W-1:0]        py_r;
  logic signed [CW-1:0]              re_r, im_r;
  logic signed [PW-1:0]              rr_r, ii_r;
  logic signed [DW-1:0]              diff_r;
  logic [jets_pkg::ITER_W-1:0]       k_r;
  logic                              mul_go_r;
  logic signed [CW-1:0]              mul_a_r, mul_b_r;
  logic                              out_valid_r;
  logic [jets_pkg::CHUNK_W-1:0]      out_chunk_r;
  logic [jets_pkg::ITER_W-1:0]       out_iter_r;

  logic                              mul_done;
  logic signed [PW-1:0]              mul_p;

  // Datapath between sequencer steps
  logic signed [CW-1:0]              start_re, start_im, next_re, next_im;
  logic signed [SW-1:0]              mag;
  logic                              escaped;
  logic signed [DW-1:0]              diff_sh, ri_ext, ri_sh;

  jets_mul #(
    .CW (CW)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (mul_go_r),
    .a     (mul_a_r),
    .b     (mul_b_r),
    .done  (mul_done),
    .p     (mul_p)
  );

  always_comb begin
    start_re = sat_coord(SUMW'(mul_p) + SUMW'(origin_real_r));
    start_im = sat_coord(SUMW'(mul_p) + SUMW'(origin_imag_r));
    mag      = SW'(rr_r) + SW'(ii_r);
    escaped  = mag > MAG_LIMIT;
    // floor((rr - ii) / 2^F) + c_re
    diff_sh  = diff_r >>> F;
    next_re  = sat_coord(SUMW'(diff_sh) + SUMW'(const_real_r));
    // floor(2*re*im / 2^F) is the product shifted by one bit less
    ri_ext   = DW'(mul_p);
    ri_sh    = ri_ext >>> (F - 1);
    next_im  = sat_coord(SUMW'(ri_sh) + SUMW'(const_imag_r));
  end

  // Configuration writes; low bits of the data word are taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      const_real_r  <= '0;
      const_imag_r  <= '0;
      step_real_r   <= '0;
      step_imag_r   <= '0;
      origin_real_r <= '0;
      origin_imag_r <= '0;
      max_iter_r    <= jets_pkg::MAX_ITER_RESET;
      chunk_id_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        jets_pkg::REG_CONST_REAL:  const_real_r  <= cfg_data;
        jets_pkg::REG_CONST_IMAG:  const_imag_r  <= cfg_data;
        jets_pkg::REG_STEP_REAL:   step_real_r   <= cfg_data;
        jets_pkg::REG_STEP_IMAG:   step_imag_r   <= cfg_data;
        jets_pkg::REG_ORIGIN_REAL: origin_real_r <= cfg_data;
        jets_pkg::REG_ORIGIN_IMAG: origin_imag_r <= cfg_data;
        jets_pkg::REG_MAX_ITER:    max_iter_r    <= cfg_data[jets_pkg::ITER_W-1:0];
        jets_pkg::REG_CHUNK_ID:    chunk_id_r    <= cfg_data[jets_pkg::CHUNK_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: every multiply is issued by a one-cycle go and awaited on done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mul_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mul_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            // x * step_real first; hold y for the second pass
            py_r     <= in_pixel_y;
            mul_a_r  <= CW'(in_pixel_x);
            mul_b_r  <= step_real_r;
            mul_go_r <= 1'b1;
            state_r  <= S_X;
          end
        end
        S_X: begin
          if (mul_done) begin
            re_r     <= start_re;
            mul_a_r  <= CW'(py_r);
            mul_b_r  <= step_imag_r;
            mul_go_r <= 1'b1;
            state_r  <= S_Y;
          end
        end
        S_Y: begin
          if (mul_done) begin
            im_r    <= start_im;
            k_r     <= '0;
            state_r <= S_TEST;
          end
        end
        S_TEST: begin
          if (k_r == max_iter_r) begin
            // never escaped: report the limit
            out_valid_r <= 1'b1;
            out_chunk_r <= chunk_id_r;
            out_iter_r  <= max_iter_r;
            state_r     <= S_IDLE;
          end else begin
            mul_a_r  <= re_r;
            mul_b_r  <= re_r;
            mul_go_r <= 1'b1;
            state_r  <= S_RR;
          end
        end
        S_RR: begin
          if (mul_done) begin
            rr_r     <= mul_p;
            mul_a_r  <= im_r;
            mul_b_r  <= im_r;
            mul_go_r <= 1'b1;
            state_r  <= S_II;
          end
        end
        S_II: begin
          if (mul_done) begin
            ii_r    <= mul_p;
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          if (escaped) begin
            out_valid_r <= 1'b1;
            out_chunk_r <= chunk_id_r;
            out_iter_r  <= k_r;
            state_r     <= S_IDLE;
          end else begin
            diff_r   <= DW'(rr_r) - DW'(ii_r);
            mul_a_r  <= re_r;
            mul_b_r  <= im_r;
            mul_go_r <= 1'b1;
            state_r  <= S_RI;
          end
        end
        S_RI: begin
          if (mul_done) begin
            // advance z and the step index together
            re_r    <= next_re;
            im_r    <= next_im;
            k_r     <= k_r + 1'b1;
            state_r <= S_TEST;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_result_chunk = out_chunk_r;
  assign out_iterations   = out_iter_r;

  `JETS_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `JETS_ASSERT_NXT(a_one_strobe, clk, rst_n, out_valid, !out_valid)
  `JETS_ASSERT_IMP(a_done_expected, clk, rst_n, mul_done, (state_r == S_X) || (state_r == S_Y) || (state_r == S_RR) || (state_r == S_II) || (state_r == S_RI))

endmodule

`default_nettype wire

### tb/julia_escape_time_pixel_tb.sv
// Self-checking testbench for the Julia escape-time pixel engine.
// Depends on jets_pkg and julia_escape_time_pixel; it predicts every result word on its own.
module julia_escape_time_pixel_tb;

  localparam int FRAC = 27;
  localparam int CW   = 32;

  // Wide enough for exact squares, their sum and the doubled cross product.
  typedef logic signed [2*CW+7:0] acc_t;
  typedef logic signed [CW-1:0]   coord_t;

  typedef struct packed {
    logic [jets_pkg::PIX_W-1:0] x;
    logic [jets_pkg::PIX_W-1:0] y;
  } pixel_t;

  typedef struct packed {
    logic [jets_pkg::CHUNK_W-1:0] chunk;
    logic [jets_pkg::ITER_W-1:0]  iters;
  } result_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           start = 1'b0;
  logic                           busy;
  logic [jets_pkg::PIX_W-1:0]     in_pixel_x = '0;
  logic [jets_pkg::PIX_W-1:0]     in_pixel_y = '0;
  logic                           out_valid;
  logic [jets_pkg::CHUNK_W-1:0]   out_result_chunk;
  logic [jets_pkg::ITER_W-1:0]    out_iterations;
  logic                           cfg_we = 1'b0;
  logic [jets_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [CW-1:0]                  cfg_data = '0;

  julia_escape_time_pixel #(
    .FRAC_BITS   (FRAC),
    .COORD_WIDTH (CW)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_pixel_x       (in_pixel_x),
    .in_pixel_y       (in_pixel_y),
    .out_valid        (out_valid),
    .out_result_chunk (out_result_chunk),
    .out_iterations   (out_iterations),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the register file, kept in step with every write we issue.
  coord_t         c_re = '0, c_im = '0;
  coord_t         dx = '0, dy = '0;
  coord_t         org_re = '0, org_im = '0;
  logic [jets_pkg::ITER_W-1:0]  iter_cap = jets_pkg::MAX_ITER_RESET;
  logic [jets_pkg::CHUNK_W-1:0] chunk_tag = '0;

  pixel_t  pixel_q[$];   // pixels waiting to be sent
  result_t depth_q[$];   // predicted result words, oldest first

  bit      idle_on = 1'b1;
  int      gap_left = 0;
  int      queued = 0;
  int      checked = 0;
  int      escaped = 0;
  int      capped = 0;
  int      views = 0;
  int      fails = 0;
  longint  cycle_cnt = 0;
  longint  budget = 0;

  // Clamp an exact value to the signed coordinate range.
  function automatic coord_t clamp_coord(acc_t v);
    acc_t top, bottom;
    top    = (acc_t'(1) <<< (CW-1)) - 1;
    bottom = -(acc_t'(1) <<< (CW-1));
    if (v > top)
      return top[CW-1:0];
    if (v < bottom)
      return bottom[CW-1:0];
    return v[CW-1:0];
  endfunction

  // Iterate z = z^2 + c from the given start and return the escape depth.
  function automatic logic [jets_pkg::ITER_W-1:0] orbit_depth(coord_t re0, coord_t im0);
    acc_t re, im, rr, ii, twice_ri, four;
    re   = acc_t'(re0);
    im   = acc_t'(im0);
    four = acc_t'(4) <<< (2*FRAC);
    for (int unsigned k = 0; k < iter_cap; k++) begin
      rr = re * re;
      ii = im * im;
      // Compare at full width: no bits dropped before the test.
      if (rr + ii > four)
        return jets_pkg::ITER_W'(k);
      twice_ri = (re * im) <<< 1;
      // Arithmetic shift floors toward minus infinity, then clamp the sum.
      re = acc_t'(clamp_coord(((rr - ii) >>> FRAC) + acc_t'(c_re)));
      im = acc_t'(clamp_coord((twice_ri >>> FRAC) + acc_t'(c_im)));
    end
    return iter_cap;
  endfunction

  function automatic result_t predict_pixel(pixel_t p);
    acc_t    px, py;
    result_t r;
    px = p.x;
    py = p.y;
    r.chunk = chunk_tag;
    r.iters = orbit_depth(clamp_coord(px * acc_t'(dx) + acc_t'(org_re)),
                          clamp_coord(py * acc_t'(dy) + acc_t'(org_im)));
    return r;
  endfunction

  // Signed value spread evenly over [-span, span].
  function automatic logic [CW-1:0] near_zero(int unsigned span);
    return CW'($urandom_range(0, 2*span)) - CW'(span);
  endfunction

  // Pixel index that lands on an end of the range now and then.
  function automatic logic [jets_pkg::PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return jets_pkg::PIX_W'($urandom());
    endcase
  endfunction

  // Queue one pixel and widen the time budget by its slowest correct run.
  task automatic add_pixel(input logic [jets_pkg::PIX_W-1:0] x,
                           input logic [jets_pkg::PIX_W-1:0] y);
    pixel_t p;
    p.x = x;
    p.y = y;
    pixel_q.push_back(p);
    queued++;
    budget += 18 + 26 * longint'(iter_cap) + 12;
  endtask

  // Write one register at the next rising edge and mirror it.
  task automatic put_reg(input logic [jets_pkg::CFG_IDX_W-1:0] idx, input logic [CW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      jets_pkg::REG_CONST_REAL:  c_re = val;
      jets_pkg::REG_CONST_IMAG:  c_im = val;
      jets_pkg::REG_STEP_REAL:   dx = val;
      jets_pkg::REG_STEP_IMAG:   dy = val;
      jets_pkg::REG_ORIGIN_REAL: org_re = val;
      jets_pkg::REG_ORIGIN_IMAG: org_im = val;
      jets_pkg::REG_MAX_ITER:    iter_cap = val[jets_pkg::ITER_W-1:0];
      jets_pkg::REG_CHUNK_ID:    chunk_tag = val[jets_pkg::CHUNK_W-1:0];
      default: ;
    endcase
  endtask

  // Program a full view: constant, steps, origin, limit and chunk tag.
  task automatic load_view(input logic [CW-1:0] cr, ci, sx, sy, ox, oy, lim, tag);
    put_reg(jets_pkg::REG_CONST_REAL, cr);
    put_reg(jets_pkg::REG_CONST_IMAG, ci);
    put_reg(jets_pkg::REG_STEP_REAL, sx);
    put_reg(jets_pkg::REG_STEP_IMAG, sy);
    put_reg(jets_pkg::REG_ORIGIN_REAL, ox);
    put_reg(jets_pkg::REG_ORIGIN_IMAG, oy);
    put_reg(jets_pkg::REG_MAX_ITER, lim);
    put_reg(jets_pkg::REG_CHUNK_ID, tag);
    @(posedge clk);
    cfg_we <= 1'b0;
    views++;
    @(negedge clk);
  endtask

  // Hold until every queued pixel is sent and every result word is back.
  task automatic wait_drain();
    do
      @(negedge clk);
    while (pixel_q.size() != 0 || depth_q.size() != 0 || busy || start);
  endtask

  // Driver: offer the head of the pixel queue; drop start for random bursts.
  always @(posedge clk) begin : drive
    pixel_t  p;
    result_t r;
    if (!rst_n) begin
      start    <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        // Word taken at this edge: predict it now, config is stable.
        p = pixel_q.pop_front();
        r = predict_pixel(p);
        depth_q.push_back(r);
        if (r.iters == iter_cap)
          capped++;
        else
          escaped++;
      end
      if (gap_left == 0 && idle_on && $urandom_range(0, 5) == 0)
        gap_left = $urandom_range(1, 10);
      if (gap_left > 0 || pixel_q.size() == 0) begin
        if (gap_left > 0)
          gap_left--;
        start      <= 1'b0;
        // Junk on the data lines while start is low must be ignored.
        in_pixel_x <= jets_pkg::PIX_W'($urandom());
        in_pixel_y <= jets_pkg::PIX_W'($urandom());
      end else begin
        start      <= 1'b1;
        in_pixel_x <= pixel_q[0].x;
        in_pixel_y <= pixel_q[0].y;
      end
    end
  end

  // Monitor: the strobe lasts one cycle, so capture every result word on sight.
  always @(posedge clk) begin : watch
    result_t want;
    if (rst_n && out_valid) begin
      if (depth_q.size() == 0) begin
        $error("unexpected result word: result_chunk %0d iterations %0d",
               out_result_chunk, out_iterations);
        fails++;
      end else begin
        want = depth_q.pop_front();
        checked++;
        if (out_result_chunk !== want.chunk) begin
          $error("result_chunk: expected %0d, actual %0d", want.chunk, out_result_chunk);
          fails++;
        end
        if (out_iterations !== want.iters) begin
          $error("iterations: expected %0d, actual %0d", want.iters, out_iterations);
          fails++;
        end
      end
    end
  end

  // Watchdog: several times the slowest correct run of what has been queued.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > 3 * budget + 20000) begin
      $error("timeout after %0d cycles, %0d result words still pending",
             cycle_cnt, depth_q.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned kind, n;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset view: z stays at zero and c is zero, so both run to the reset limit.
    add_pixel(8'd0, 8'd0);
    add_pixel(8'd255, 8'd255);
    wait_drain();

    // Zero limit, written with junk in the upper bits; tag also from low bits.
    load_view(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'h0000_0100, 32'hFFFF_FFAB);
    add_pixel(8'd0, 8'd0);
    add_pixel(8'd255, 8'd0);
    add_pixel(8'd0, 8'd255);
    wait_drain();

    // Start point saturates at both ends of the range.
    load_view(32'd0, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              32'd3, 32'h5A);
    add_pixel(8'd255, 8'd255);
    add_pixel(8'd1, 8'd1);
    add_pixel(8'd0, 8'd0);
    add_pixel(8'd0, 8'd255);
    add_pixel(8'd255, 8'd0);
    add_pixel(8'd128, 8'd3);
    wait_drain();

    // |z| exactly 2 must not escape; one LSB more must. Then z^2 + c clamps high.
    load_view(32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'd1, 32'h1000_0000, 32'd0,
              32'd5, 32'hFF);
    add_pixel(8'd0, 8'd0);
    add_pixel(8'd1, 8'd0);
    add_pixel(8'd0, 8'd1);
    add_pixel(8'd255, 8'd255);
    wait_drain();

    // z = 2i: real part clamps low, imaginary part lands on the top end.
    load_view(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0, 32'h1000_0000,
              32'd4, 32'h01);
    add_pixel(8'd0, 8'd0);
    wait_drain();

    // Classic view near c = -0.8 + 0.156i with the widest limit.
    load_view(32'hF999_999A, 32'h013F_7CED, 32'h0018_0000, 32'h0018_0000,
              32'hF400_0000, 32'hF400_0000, 32'd255, 32'h80);
    add_pixel(8'd128, 8'd128);
    add_pixel(8'd0, 8'd0);
    add_pixel(8'd200, 8'd100);
    add_pixel(8'd90, 8'd160);

    // Random views: mostly well-behaved windows, some wild, a few long orbits.
    while (queued < 1850) begin
      wait_drain();
      idle_on = (queued < 1700) && ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        load_view($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                  $urandom(), $urandom(), $urandom());
        n = $urandom_range(20, 40);
      end else if (kind == 1) begin
        load_view(near_zero(32'h0600_0000), near_zero(32'h0600_0000),
                  near_zero(32'h0020_0000), near_zero(32'h0020_0000),
                  near_zero(32'h0800_0000), near_zero(32'h0800_0000),
                  $urandom_range(200, 255), $urandom());
        n = 3;
      end else begin
        load_view(near_zero(32'h0C00_0000), near_zero(32'h0C00_0000),
                  near_zero(32'h0040_0000), near_zero(32'h0040_0000),
                  near_zero(32'h1400_0000), near_zero(32'h1400_0000),
                  ($urandom() & 32'hFFFF_FF00) | $urandom_range(1, 20), $urandom());
        n = $urandom_range(30, 60);
      end
      for (int unsigned i = 0; i < n; i++)
        add_pixel(pick_pixel(), pick_pixel());
    end

    wait_drain();
    // Leave room for a stray result word to show up.
    repeat (64) @(posedge clk);
    $display("checked %0d result words over %0d register views", checked, views);
    $display("%0d pixels escaped early, %0d ran to the iteration limit", escaped, capped);
    if (fails == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/jets_pkg.sv
hdl/jets_mul.sv
hdl/julia_escape_time_pixel.sv
tb/julia_escape_time_pixel_tb.sv
